// File: rtl/core/csp_pkg.sv
package csp_pkg;

   localparam logic [2:0] STATUS_INVALID = 3'd0;
   localparam logic [2:0] STATUS_HEX6    = 3'd1;
   localparam logic [2:0] STATUS_HEX3    = 3'd2;
   localparam logic [2:0] STATUS_DEC565  = 3'd3;
   localparam logic [2:0] STATUS_HASH    = 3'd4;

   localparam logic [7:0] CHAR_END   = 8'h00;
   localparam logic [7:0] CHAR_POUND = 8'h23;

   localparam logic [3:0] LENGTH_MAX  = 4'd8;
   localparam logic [3:0] HEX_LEN_MAX = 4'd7;
   localparam logic [2:0] RUN_MAX     = 3'd7;
   localparam logic [2:0] RUN_SIX     = 3'd6;
   localparam logic [2:0] RUN_THREE   = 3'd3;

   typedef struct packed {
      logic [3:0]  length_count;
      logic        leading_hash;
      logic [2:0]  hex_run_count;
      logic        hex_run_open;
      logic [23:0] hex_value;
      logic        all_digits;
      logic [15:0] decimal_value;
      logic [15:0] running_hash;
   } parse_state_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] name_hash;
   } result_type;

   function automatic logic is_dec(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] t;
      t = 8'h00;
      if (is_dec(c)) begin
         t = c - 8'h30;
      end else if ((c >= 8'h61) && (c <= 8'h66)) begin
         t = c - 8'h57;
      end else if ((c >= 8'h41) && (c <= 8'h46)) begin
         t = c - 8'h37;
      end
      return t[3:0];
   endfunction

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5a)) ? (c + 8'h20) : c;
   endfunction

   function automatic logic [7:0] expand5(input logic [4:0] v);
      logic [13:0] p;
      p = 14'(v) * 14'd527 + 14'd23;
      return p[13:6];
   endfunction

   function automatic logic [7:0] expand6(input logic [5:0] v);
      logic [13:0] p;
      p = 14'(v) * 14'd259 + 14'd33;
      return p[13:6];
   endfunction

endpackage

// File: rtl/core/csp_accum.sv
module csp_accum
   import csp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            take,
   input  logic [7:0]      char_code,
   output parse_state_type state
);

   parse_state_type st_ff;
   parse_state_type st_in;
   parse_state_type st_clr;
   logic [7:0]      digit;

   always_comb begin
      st_clr = '0;
      st_clr.hex_run_open = 1'b1;
      st_clr.all_digits   = 1'b1;
      digit = char_code - 8'h30;
      st_in = st_ff;
      if (take) begin
         if (char_code == CHAR_END) begin
            st_in = st_clr;
         end else begin
            if (st_ff.length_count == 4'd0) begin
               st_in.leading_hash = (char_code == CHAR_POUND);
            end else if (st_ff.leading_hash && st_ff.hex_run_open) begin
               if (is_hex(char_code)) begin
                  if (st_ff.hex_run_count < RUN_MAX) begin
                     st_in.hex_run_count = st_ff.hex_run_count + 3'd1;
                  end
                  st_in.hex_value = {st_ff.hex_value[19:0], hex_val(char_code)};
               end else begin
                  st_in.hex_run_open = 1'b0;
               end
            end
            if (is_dec(char_code)) begin
               st_in.decimal_value = (st_ff.decimal_value << 3) + (st_ff.decimal_value << 1)
                                   + 16'(digit);
            end else begin
               st_in.all_digits = 1'b0;
            end
            st_in.running_hash = (st_ff.running_hash << 6) - st_ff.running_hash
                               + 16'(fold_case(char_code));
            if (st_ff.length_count < LENGTH_MAX) begin
               st_in.length_count = st_ff.length_count + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= st_clr;
      end else begin
         st_ff <= st_in;
      end
   end

   assign state = st_ff;

endmodule

// File: rtl/core/csp_format.sv
module csp_format
   import csp_pkg::*;
(
   input  parse_state_type state,
   output result_type      result
);

   always_comb begin
      result = '0;
      result.name_hash = state.running_hash;
      if (state.leading_hash) begin
         result.status = STATUS_INVALID;
         if (state.length_count <= HEX_LEN_MAX) begin
            if (state.hex_run_count == RUN_SIX) begin
               result.status = STATUS_HEX6;
               result.red    = state.hex_value[23:16];
               result.green  = state.hex_value[15:8];
               result.blue   = state.hex_value[7:0];
            end else if (state.hex_run_count == RUN_THREE) begin
               result.status = STATUS_HEX3;
               result.red    = {state.hex_value[11:8], state.hex_value[11:8]};
               result.green  = {state.hex_value[7:4], state.hex_value[7:4]};
               result.blue   = {state.hex_value[3:0], state.hex_value[3:0]};
            end
         end
      end else if (state.all_digits) begin
         result.status = STATUS_DEC565;
         result.red    = expand5(state.decimal_value[15:11]);
         result.green  = expand6(state.decimal_value[10:5]);
         result.blue   = expand5(state.decimal_value[4:0]);
      end else begin
         result.status = STATUS_HASH;
      end
   end

endmodule

// File: rtl/core/color_spec_parser_core.sv
// channel | valid     | stall     | payload
// req     | req_valid | req_stall | req_char_code
// rsp     | rsp_valid | rsp_stall | rsp_status, rsp_red, rsp_green, rsp_blue, rsp_name_hash
//
// one byte is taken every cycle unless req_stall is high; a result appears in the cycle after its end byte is taken
// the parse state sits in registers and is updated by one short pass per byte
// synchronous reset clears the parse state and drops rsp_valid
// req_stall rises only while a result waits under rsp_stall
module color_spec_parser_core
   import csp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [15:0] rsp_name_hash
);

   parse_state_type state;
   result_type      result;
   result_type      rsp_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            take;
   logic            done;

   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign take         = req_valid & ~req_stall;
   assign done         = take & (req_char_code == CHAR_END);
   assign rsp_valid_in = done | (rsp_valid_ff & rsp_stall);

   csp_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .char_code (req_char_code),
      .state     (state)
   );

   csp_format u_format (
      .state  (state),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_ff.status;
   assign rsp_red       = rsp_ff.red;
   assign rsp_green     = rsp_ff.green;
   assign rsp_blue      = rsp_ff.blue;
   assign rsp_name_hash = rsp_ff.name_hash;

`ifndef SYNTHESIS
   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_char_code == CHAR_END)) |=> rsp_valid)
      else $error("end byte did not produce a result");

   a_held_result_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input taken while a result is held");

   a_no_color_without_rgb: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_status == STATUS_INVALID) || (rsp_status == STATUS_HASH)))
      |-> ((rsp_red == 8'd0) && (rsp_green == 8'd0) && (rsp_blue == 8'd0)))
      else $error("color channels set for a status without color");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= STATUS_HASH))
      else $error("status code out of range");
`endif

endmodule
